// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the color converter.
// Every macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every edge outside reset.
`define RHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define RHC_ASSERT_IMP(lbl, ante, cons, msg) \
  `RHC_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define RHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  `RHC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== hdl/rhc_pkg.sv =====
// Shared constants for the RGB to HSV converter.
// No dependencies; used by rhc_div, rgb_to_hsv_convert and tb_top.
package rhc_pkg;

  localparam int FRAC_BITS_DEF = 12;  // Q4.12 by default
  localparam int IN_W          = 16;  // width of each input channel
  localparam int HUE_W         = 12;  // width of hue_out
  localparam int OUT_W         = 13;  // width of sat_out, val_out, alpha_out

endpackage

// ===== hdl/rhc_div.sv =====
// Pipelined restoring divider: quo = floor(num * 2^FRAC_BITS / den), one quotient bit per stage.
// Requires num <= den and den != 0. Depends on rhc_pkg; stage enables come from the top level.
module rhc_div #(
  parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEF,
  parameter int DEN_W     = FRAC_BITS + 1
) (
  input  logic                 clk,
  input  logic [FRAC_BITS:0]   load,
  input  logic [DEN_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  output logic [FRAC_BITS:0]   quo
);

  localparam int Q = FRAC_BITS + 1;

  logic [DEN_W-1:0] rem  [Q-1];
  logic [DEN_W-1:0] dreg [Q-1];
  logic [Q-1:0]     qr   [Q];

  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   sub;
    logic [DEN_W-1:0] d;
    logic [Q-1:0]     qprev;
    logic             qbit;

    if (k == 0) begin : g_first
      // Integer bit: compare without shifting.
      assign trial = {1'b0, num};
      assign d     = den;
      assign qprev = '0;
    end else begin : g_rest
      assign trial = {rem[k-1], 1'b0};
      assign d     = dreg[k-1];
      assign qprev = qr[k-1];
    end

    assign sub  = trial - {1'b0, d};
    assign qbit = ~sub[DEN_W];

    always_ff @(posedge clk) begin
      if (load[k]) begin
        qr[k] <= {qprev[Q-2:0], qbit};
      end
    end

    if (k < Q - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (load[k]) begin
          rem[k]  <= qbit ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
          dreg[k] <= d;
        end
      end
    end
  end

  assign quo = qr[Q-1];

endmodule

// ===== hdl/rgb_to_hsv_convert.sv =====
// RGB to HSV converter: throughput one transaction per cycle while out_ready is not held low.
// Three stages clamp, sort and form the hue fraction; FRAC_BITS+1
// divider stages (one quotient bit each) follow, hue and saturation in parallel.
// Stalls propagate back through full stages only, so empty stages keep filling while the output waits.
// Synchronous active-high reset empties the pipeline; it clears only the valid bits.
`include "assert_macros.svh"

module rgb_to_hsv_convert #(
  parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [rhc_pkg::IN_W-1:0]     red_in,
  input  logic signed [rhc_pkg::IN_W-1:0]     green_in,
  input  logic signed [rhc_pkg::IN_W-1:0]     blue_in,
  input  logic signed [rhc_pkg::IN_W-1:0]     alpha_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rhc_pkg::HUE_W-1:0]           hue_out,
  output logic [rhc_pkg::OUT_W-1:0]           sat_out,
  output logic [rhc_pkg::OUT_W-1:0]           val_out,
  output logic [rhc_pkg::OUT_W-1:0]           alpha_out
);

  localparam int W    = FRAC_BITS + 1;       // clamped channel, 0..ONE
  localparam int Q    = FRAC_BITS + 1;       // quotient bits
  localparam int HD_W = FRAC_BITS + 3;       // holds 6 * range
  localparam int NS   = 3 + Q;               // total stages
  localparam int CE_W = rhc_pkg::IN_W + 2;
  localparam logic signed [CE_W-1:0] ONE_S = CE_W'(1 << FRAC_BITS);

  // Sector codes; the hue sector is twice the code.
  localparam logic [1:0] SEC_RED_UP = 2'd0;  // red max, g >= b
  localparam logic [1:0] SEC_GREEN  = 2'd1;
  localparam logic [1:0] SEC_BLUE   = 2'd2;
  localparam logic [1:0] SEC_RED_DN = 2'd3;  // red max, g < b

  function automatic logic [W-1:0] clamp(input logic signed [rhc_pkg::IN_W-1:0] x);
    logic signed [CE_W-1:0] e;
    e = CE_W'(x);
    if (e < 0) return '0;
    else if (e > ONE_S) return W'(ONE_S);
    else return e[W-1:0];
  endfunction

  // Stage control
  logic [NS-1:0] v;
  logic [NS-1:0] load;
  logic [NS-1:0] v_up;

  assign load[NS-1] = ~v[NS-1] | out_ready;
  for (genvar i = 0; i < NS - 1; i++) begin : g_load
    assign load[i] = ~v[i] | load[i+1];
  end
  assign v_up = {v[NS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (load[i]) v[i] <= v_up[i];
      end
    end
  end

  assign in_ready  = load[0];
  assign out_valid = v[NS-1];

  // Stage 0: clamp
  logic [W-1:0] r0, g0, b0, a0;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      r0 <= clamp(red_in);
      g0 <= clamp(green_in);
      b0 <= clamp(blue_in);
      a0 <= clamp(alpha_in);
    end
  end

  // Stage 1: max, min, sector, difference
  logic               r_big, g_big;
  logic [W-1:0]       mx_c, mn_c;
  logic [1:0]         sec_c;
  logic signed [W:0]  diff_c;
  logic [W-1:0]       mx1, rng1, a1;
  logic signed [W:0]  diff1;
  logic [1:0]         sec1;

  always_comb begin
    r_big = (r0 >= g0) && (r0 >= b0);
    g_big = (g0 >= b0);
    mn_c  = r0;
    if (g0 < mn_c) mn_c = g0;
    if (b0 < mn_c) mn_c = b0;
    if (r_big) begin
      mx_c   = r0;
      diff_c = $signed({1'b0, g0}) - $signed({1'b0, b0});
      sec_c  = (g0 >= b0) ? SEC_RED_UP : SEC_RED_DN;
    end else if (g_big) begin
      mx_c   = g0;
      diff_c = $signed({1'b0, b0}) - $signed({1'b0, r0});
      sec_c  = SEC_GREEN;
    end else begin
      mx_c   = b0;
      diff_c = $signed({1'b0, r0}) - $signed({1'b0, g0});
      sec_c  = SEC_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      mx1   <= mx_c;
      rng1  <= mx_c - mn_c;
      diff1 <= diff_c;
      sec1  <= sec_c;
      a1    <= a0;
    end
  end

  // Stage 2: divider operands; a zero divisor becomes one over a zero dividend
  logic [HD_W-1:0] rng2x, base_c, nh_c, dh_c;
  logic [W-1:0]    ds_c;
  logic [HD_W-1:0] nh2, dh2;
  logic [W-1:0]    ns2, ds2, mx2, a2;

  always_comb begin
    rng2x  = HD_W'({rng1, 1'b0});
    base_c = (sec1[0] ? rng2x : '0) + (sec1[1] ? (rng2x << 1) : '0);
    nh_c   = base_c + HD_W'(diff1);
    dh_c   = (rng1 == '0) ? HD_W'(1) : ((HD_W'(rng1) << 2) + (HD_W'(rng1) << 1));
    ds_c   = (mx1 == '0) ? W'(1) : mx1;
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      nh2 <= nh_c;
      dh2 <= dh_c;
      ns2 <= rng1;
      ds2 <= ds_c;
      mx2 <= mx1;
      a2  <= a1;
    end
  end

  // Divider stages
  logic [Q-1:0] quo_h, quo_s;

  rhc_div #(.FRAC_BITS(FRAC_BITS), .DEN_W(HD_W)) u_div_hue (
    .clk  (clk),
    .load (load[NS-1:3]),
    .num  (nh2),
    .den  (dh2),
    .quo  (quo_h)
  );

  rhc_div #(.FRAC_BITS(FRAC_BITS), .DEN_W(W)) u_div_sat (
    .clk  (clk),
    .load (load[NS-1:3]),
    .num  (ns2),
    .den  (ds2),
    .quo  (quo_s)
  );

  // Carry value and alpha alongside the dividers
  logic [W-1:0] mxp [Q];
  logic [W-1:0] ap  [Q];

  for (genvar k = 0; k < Q; k++) begin : g_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (load[3]) begin
          mxp[0] <= mx2;
          ap[0]  <= a2;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (load[3+k]) begin
          mxp[k] <= mxp[k-1];
          ap[k]  <= ap[k-1];
        end
      end
    end
  end

  // Fit results to the output field widths
  logic [Q+rhc_pkg::HUE_W-1:0] hue_x;
  logic [Q+rhc_pkg::OUT_W-1:0] sat_x;
  logic [W+rhc_pkg::OUT_W-1:0] val_x, alpha_x;

  assign hue_x     = {{rhc_pkg::HUE_W{1'b0}}, quo_h};
  assign sat_x     = {{rhc_pkg::OUT_W{1'b0}}, quo_s};
  assign val_x     = {{rhc_pkg::OUT_W{1'b0}}, mxp[Q-1]};
  assign alpha_x   = {{rhc_pkg::OUT_W{1'b0}}, ap[Q-1]};
  assign hue_out   = hue_x[rhc_pkg::HUE_W-1:0];
  assign sat_out   = sat_x[rhc_pkg::OUT_W-1:0];
  assign val_out   = val_x[rhc_pkg::OUT_W-1:0];
  assign alpha_out = alpha_x[rhc_pkg::OUT_W-1:0];

  // Checks
  `RHC_ASSERT_IMP(a_hue_below_turn, v[NS-1], !quo_h[Q-1], "hue quotient reached a full turn")
  `RHC_ASSERT_IMP(a_sat_at_most_one, v[NS-1] && quo_s[Q-1], quo_s[Q-2:0] == '0,
                  "saturation quotient above one")
  `RHC_ASSERT_NEXT(a_last_advance, v[NS-2] && load[NS-1], v[NS-1],
                   "transaction lost entering the output stage")

endmodule

// ===== bench/tb_top.sv =====
// Testbench for rgb_to_hsv_convert: directed and random RGBA pixels, with idle
// cycles and back-pressure on both sides. Depends on rhc_pkg and the converter RTL.
// An in-bench predictor computes each expected HSV result and checks it in order.
`timescale 1ns / 1ps

module tb_top;
  localparam int FRAC_BITS_DEF = rhc_pkg::FRAC_BITS_DEF;
  localparam int IN_W          = rhc_pkg::IN_W;
  localparam int HUE_W         = rhc_pkg::HUE_W;
  localparam int OUT_W         = rhc_pkg::OUT_W;

  localparam int ONE_Q        = 1 << FRAC_BITS_DEF;
  localparam int PIPE_LATENCY = FRAC_BITS_DEF + 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [OUT_W-1:0] sat;
    logic [OUT_W-1:0] val;
    logic [OUT_W-1:0] alpha;
  } hsv_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [IN_W-1:0] red_in = '0;
  logic signed [IN_W-1:0] green_in = '0;
  logic signed [IN_W-1:0] blue_in = '0;
  logic signed [IN_W-1:0] alpha_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [HUE_W-1:0] hue_out;
  logic [OUT_W-1:0] sat_out;
  logic [OUT_W-1:0] val_out;
  logic [OUT_W-1:0] alpha_out;

  hsv_t pending_hsv[$];
  int   mismatch_count = 0;
  int   pixels_sent = 0;
  int   pixels_checked = 0;
  int   cycle_count = 0;
  logic tx_idle = 1'b1;
  logic rx_idle = 1'b1;
  int   hold_req = 0;
  int   hold_ack = 0;
  int   hold_left = 0;
  int   rx_stall_left = 0;

  rgb_to_hsv_convert uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .alpha_in  (alpha_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hue_out   (hue_out),
    .sat_out   (sat_out),
    .val_out   (val_out),
    .alpha_out (alpha_out)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_hsv.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic longint clamp_q12(input logic [IN_W-1:0] raw);
    longint v;
    v = longint'($signed(raw));
    if (v < 0) v = 0;
    if (v > ONE_Q) v = ONE_Q;
    return v;
  endfunction

  function automatic hsv_t predict_hsv(input logic [IN_W-1:0] r_raw, g_raw, b_raw, a_raw);
    longint r, g, b, a, mx, mn, span, sector, diff, hue, sat;
    hsv_t res;
    r = clamp_q12(r_raw);
    g = clamp_q12(g_raw);
    b = clamp_q12(b_raw);
    a = clamp_q12(a_raw);
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    span = mx - mn;
    hue = 0;
    sat = 0;
    if (span != 0) begin
      // ties resolve to red first, then green
      if (mx == r) begin
        diff = g - b;
        sector = (g >= b) ? 0 : 6;
      end else if (mx == g) begin
        diff = b - r;
        sector = 2;
      end else begin
        diff = r - g;
        sector = 4;
      end
      hue = ((sector * span + diff) * ONE_Q) / (6 * span);
    end
    if (mx != 0) sat = (span * ONE_Q) / mx;
    res.hue   = hue[HUE_W-1:0];
    res.sat   = sat[OUT_W-1:0];
    res.val   = mx[OUT_W-1:0];
    res.alpha = a[OUT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_PRINTS)
      $display("mismatch at pixel %0d: %s got %0d want %0d", pixels_checked, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_pixel();
    hsv_t want;
    if (pending_hsv.size() == 0) begin
      report_mismatch("unexpected result, hue", hue_out, 0);
    end else begin
      want = pending_hsv.pop_front();
      if (hue_out !== want.hue) report_mismatch("hue_out", hue_out, want.hue);
      if (sat_out !== want.sat) report_mismatch("sat_out", sat_out, want.sat);
      if (val_out !== want.val) report_mismatch("val_out", val_out, want.val);
      if (alpha_out !== want.alpha) report_mismatch("alpha_out", alpha_out, want.alpha);
    end
    pixels_checked++;
  endtask

  // Long receiver hold-off, counted here; requested by bumping hold_req.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: check each transaction, then draw the stall before the next one.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_pixel();
        rx_stall_left = rx_idle ? $urandom_range(0, 11) : 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else if (rx_stall_left > 0) begin
        out_ready <= 1'b0;
        rx_stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Called right after a rising edge; returns at the edge that accepted the pixel.
  task automatic send_pixel(input logic [IN_W-1:0] r, g, b, a);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    alpha_in <= a;
    do @(posedge clk); while (!in_ready);
    pending_hsv.push_back(predict_hsv(r, g, b, a));
    pixels_sent++;
  endtask

  // Stop offering and wait for every outstanding result, plus pipeline slack.
  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (pending_hsv.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] rand_channel();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return IN_W'($urandom_range(0, ONE_Q));
    if (pick < 80) return ($urandom_range(0, 1) != 0) ? IN_W'(ONE_Q) : '0;
    return IN_W'($urandom);
  endfunction

  task automatic test_directed();
    send_pixel(16'd0, 16'd0, 16'd0, 16'd0);              // black
    send_pixel(16'd4096, 16'd4096, 16'd4096, 16'd4096);  // white
    send_pixel(16'd2048, 16'd2048, 16'd2048, 16'd2048);  // mid grey
    send_pixel(16'h8000, 16'h8000, 16'h8000, 16'h8000);  // most negative
    send_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);  // far over range
    send_pixel(16'd4096, 16'd0, 16'd0, 16'd4096);        // pure red
    send_pixel(16'd0, 16'd4096, 16'd0, 16'd0);           // pure green
    send_pixel(16'd0, 16'd0, 16'd4096, 16'd1);           // pure blue
    send_pixel(16'd4096, 16'd1000, 16'd3000, 16'd2000);  // red max, green below blue
    send_pixel(16'd4096, 16'd4096, 16'd0, 16'd4095);     // red and green tie
    send_pixel(16'd0, 16'd4096, 16'd4096, 16'hFFFF);     // green and blue tie
    send_pixel(16'd4096, 16'd0, 16'd4096, 16'd4097);     // red and blue tie
    send_pixel(16'd4097, 16'hFFFF, 16'd4095, 16'd0);     // just outside the clamp limits
    send_pixel(16'd1, 16'd0, 16'd0, 16'd1);              // smallest nonzero
    send_pixel(16'd4095, 16'd4094, 16'd4096, 16'd3000);  // blue max near one
    send_pixel(16'd100, 16'hFFFF, 16'h8001, 16'd50);     // mixed negatives
    send_pixel(16'd3000, 16'd3001, 16'd2999, 16'd10);    // tiny range
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000);  // negatives give black
    send_pixel(16'd1, 16'd2, 16'd3, 16'h7FFF);           // dim blue max
    send_pixel(16'd4096, 16'd1, 16'd0, 16'd0);           // hue just above zero
    send_pixel(16'd4096, 16'd0, 16'd1, 16'd0);           // hue just below full turn
    drain_pixels();
  endtask

  task automatic test_random_raw(input int count);
    repeat (count) send_pixel(IN_W'($urandom), IN_W'($urandom), IN_W'($urandom),
                              IN_W'($urandom));
    drain_pixels();
  endtask

  task automatic test_random_mixed(input int count);
    repeat (count) send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel());
    drain_pixels();
  endtask

  // Pixels close to grey keep the range small and exercise the divider hard.
  task automatic test_near_grey(input int count);
    int base;
    repeat (count) begin
      base = $urandom_range(0, ONE_Q);
      send_pixel(IN_W'(base + $urandom_range(0, 3)), IN_W'(base + $urandom_range(0, 3)),
                 IN_W'(base - $urandom_range(0, 3)), rand_channel());
    end
    drain_pixels();
  endtask

  task automatic test_backpressure(input int count);
    tx_idle  <= 1'b0;
    hold_req <= hold_req + 1;
    repeat (count) send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel());
    drain_pixels();
    tx_idle <= 1'b1;
  endtask

  task automatic test_full_rate(input int count);
    tx_idle <= 1'b0;
    rx_idle <= 1'b0;
    repeat (count) send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel());
    drain_pixels();
    tx_idle <= 1'b1;
    rx_idle <= 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_raw(300);
    test_random_mixed(900);
    test_backpressure(80);
    test_full_rate(200);
    test_near_grey(200);
    $display("sent %0d pixels, checked %0d results in %0d cycles", pixels_sent,
             pixels_checked, cycle_count);
    $display("covered clamping, ties, grey and black pixels, stalls and full rate");
    if (mismatch_count == 0 && pending_hsv.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/rhc_pkg.sv
hdl/rhc_div.sv
hdl/rgb_to_hsv_convert.sv
bench/tb_top.sv
